// File: rtl/gte_pkg.sv
package gte_pkg;

    localparam int TABLE_LEVELS = 19;
    localparam int DEPTH_W      = 5;
    localparam int COORD_W      = 32;
    localparam int CODE_W       = 40;
    localparam int NUM_CHARS    = 8;
    localparam int GROUP_BITS   = 5;

    typedef struct packed {
        logic signed [31:0] longitude;
        logic signed [31:0] latitude;
        logic        [23:0] tolerance;
    } point_t;

    typedef struct packed {
        logic [6:0] char_0;
        logic [6:0] char_1;
        logic [6:0] char_2;
        logic [6:0] char_3;
        logic [6:0] char_4;
        logic [6:0] char_5;
        logic [6:0] char_6;
        logic [6:0] char_7;
        logic [3:0] code_length;
    } code_t;

    localparam logic signed [31:0] LON_HALF = 32'sd1800000000;
    localparam logic signed [31:0] LAT_HALF = 32'sd900000000;
    localparam logic [31:0]        LON_SPAN = 32'd3600000000;
    localparam logic [31:0]        LAT_SPAN = 32'd1800000000;

    localparam logic [23:0] LEVEL_TOL [TABLE_LEVELS] = '{
        24'd5400000, 24'd2700000, 24'd1300000, 24'd680000, 24'd340000,
        24'd170000,  24'd85000,   24'd42000,   24'd21000,  24'd10000,
        24'd5300,    24'd2600,    24'd1300,    24'd650,    24'd320,
        24'd160,     24'd83,      24'd41,      24'd20
    };

    localparam logic [255:0] B32_ALPHABET = "0123456789bcdefghjkmnpqrstuvwxyz";

    localparam logic [6:0] CHAR_BANG = 7'h21;
    localparam logic [6:0] CHAR_NONE = 7'h00;

    function automatic logic [6:0] b32_char(input logic [4:0] idx);
        logic [7:0] c;
        c = B32_ALPHABET[8 * (31 - int'(idx)) +: 8];
        return c[6:0];
    endfunction

endpackage

// File: rtl/geohash_tile_encoder.sv
// Pipeline from point beat to code beat: one input stage, one bisection stage per level,
// one character stage. Throughput: one point per cycle while code_ready is high;
// a full stage holds its beat only while the next is full and cannot drain.
// Reset (rst_n low, async): all stage valid bits and the output valid clear;
// data registers are not reset.
module geohash_tile_encoder
    import gte_pkg::*;
#(
    parameter int MAX_DEPTH = 19
)
(
    input  logic   clk,
    input  logic   rst_n,
    input  logic   point_valid,
    output logic   point_ready,
    input  point_t point,
    output logic   code_valid,
    input  logic   code_ready,
    output code_t  code
);

    localparam int BITS_W = 2 * MAX_DEPTH;

    logic                valid_reg   [0:MAX_DEPTH];
    logic                stage_ready [0:MAX_DEPTH+1];

    logic [COORD_W-1:0]  xr_reg      [0:MAX_DEPTH-1];
    logic [COORD_W-1:0]  yr_reg      [0:MAX_DEPTH-1];
    logic [COORD_W-1:0]  xr_next     [0:MAX_DEPTH-1];
    logic [COORD_W-1:0]  yr_next     [0:MAX_DEPTH-1];
    logic [BITS_W-1:0]   bits_reg    [0:MAX_DEPTH];
    logic [BITS_W-1:0]   bits_next   [0:MAX_DEPTH];
    logic [DEPTH_W-1:0]  depth_reg   [0:MAX_DEPTH];
    logic [DEPTH_W-1:0]  depth_next  [0:MAX_DEPTH];
    logic                oor_reg     [0:MAX_DEPTH];
    logic                oor_next    [0:MAX_DEPTH];

    logic                code_valid_reg;
    code_t               code_reg;
    code_t               code_next;

    // backpressure: a stage takes a beat when empty or when it drains this cycle
    always_comb
    begin
        stage_ready[MAX_DEPTH+1] = !code_valid_reg || code_ready;
        for (int k = MAX_DEPTH; k >= 0; k--)
        begin
            stage_ready[k] = !valid_reg[k] || stage_ready[k+1];
        end
    end

    assign point_ready = stage_ready[0];

    // input stage: range check, offset, depth from tolerance table
    always_comb
    begin
        logic [DEPTH_W-1:0] cnt;
        cnt = '0;
        for (int i = 0; i < MAX_DEPTH; i++)
        begin
            cnt = cnt + DEPTH_W'(point.tolerance <= LEVEL_TOL[i]);
        end
        depth_next[0] = cnt;
        oor_next[0]   = (point.longitude < -LON_HALF) || (point.longitude > LON_HALF) ||
                        (point.latitude  < -LAT_HALF) || (point.latitude  > LAT_HALF);
        xr_next[0]    = COORD_W'(point.longitude) + COORD_W'(LON_HALF);
        yr_next[0]    = COORD_W'(point.latitude)  + COORD_W'(LAT_HALF);
        bits_next[0]  = '0;
    end

    // one bisection level per stage; residual kept doubled against the full span
    for (genvar k = 1; k <= MAX_DEPTH; k++)
    begin : g_level
        logic [COORD_W:0] x2;
        logic [COORD_W:0] y2;
        logic             xb;
        logic             yb;

        always_comb
        begin
            x2 = {xr_reg[k-1], 1'b0};
            y2 = {yr_reg[k-1], 1'b0};
            xb = x2 >= {1'b0, LON_SPAN};
            yb = y2 >= {1'b0, LAT_SPAN};
            bits_next[k]  = (bits_reg[k-1] << 2) | BITS_W'({xb, yb});
            depth_next[k] = depth_reg[k-1];
            oor_next[k]   = oor_reg[k-1];
        end

        if (k < MAX_DEPTH)
        begin : g_resid
            always_comb
            begin
                xr_next[k] = xb ? COORD_W'(x2 - {1'b0, LON_SPAN}) : x2[COORD_W-1:0];
                yr_next[k] = yb ? COORD_W'(y2 - {1'b0, LAT_SPAN}) : y2[COORD_W-1:0];
            end
        end
    end

    // character stage
    always_comb
    begin
        logic [BITS_W-1:0] bits_m;
        logic [CODE_W-1:0] word;
        logic [2:0]        grp;
        logic [6:0]        chr [NUM_CHARS];
        bits_m = bits_reg[MAX_DEPTH];
        for (int l = 0; l < MAX_DEPTH; l++)
        begin
            if (DEPTH_W'(l) >= depth_reg[MAX_DEPTH])
            begin
                bits_m[BITS_W-1-2*l -: 2] = 2'b00;
            end
        end
        word = CODE_W'(bits_m) << (CODE_W - BITS_W);
        grp  = '0;
        for (int j = 1; j < NUM_CHARS; j++)
        begin
            grp = grp + 3'({depth_reg[MAX_DEPTH], 1'b0} >= 6'(GROUP_BITS * j));
        end
        for (int i = 0; i < NUM_CHARS; i++)
        begin
            if (oor_reg[MAX_DEPTH])
            begin
                chr[i] = (i == 0) ? CHAR_BANG : CHAR_NONE;
            end
            else if (3'(i) <= grp)
            begin
                chr[i] = b32_char(word[CODE_W-1-GROUP_BITS*i -: GROUP_BITS]);
            end
            else
            begin
                chr[i] = CHAR_NONE;
            end
        end
        code_next.char_0      = chr[0];
        code_next.char_1      = chr[1];
        code_next.char_2      = chr[2];
        code_next.char_3      = chr[3];
        code_next.char_4      = chr[4];
        code_next.char_5      = chr[5];
        code_next.char_6      = chr[6];
        code_next.char_7      = chr[7];
        code_next.code_length = oor_reg[MAX_DEPTH] ? 4'd1 : 4'(grp) + 4'd1;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            for (int k = 0; k <= MAX_DEPTH; k++)
            begin
                valid_reg[k] <= 1'b0;
            end
            code_valid_reg <= 1'b0;
        end
        else
        begin
            if (stage_ready[0])
            begin
                valid_reg[0] <= point_valid;
            end
            for (int k = 1; k <= MAX_DEPTH; k++)
            begin
                if (stage_ready[k])
                begin
                    valid_reg[k] <= valid_reg[k-1];
                end
            end
            if (stage_ready[MAX_DEPTH+1])
            begin
                code_valid_reg <= valid_reg[MAX_DEPTH];
            end
        end
    end

    always_ff @(posedge clk)
    begin
        for (int k = 0; k <= MAX_DEPTH; k++)
        begin
            if (stage_ready[k])
            begin
                bits_reg[k]  <= bits_next[k];
                depth_reg[k] <= depth_next[k];
                oor_reg[k]   <= oor_next[k];
            end
        end
        for (int k = 0; k < MAX_DEPTH; k++)
        begin
            if (stage_ready[k])
            begin
                xr_reg[k] <= xr_next[k];
                yr_reg[k] <= yr_next[k];
            end
        end
        if (stage_ready[MAX_DEPTH+1])
        begin
            code_reg <= code_next;
        end
    end

    assign code_valid = code_valid_reg;
    assign code       = code_reg;

endmodule

// File: rtl/gte_checker.sv
module gte_checker
    import gte_pkg::*;
(
    input logic   clk,
    input logic   rst_n,
    input logic   point_valid,
    input logic   point_ready,
    input point_t point,
    input logic   code_valid,
    input logic   code_ready,
    input code_t  code
);

    a_reset_idle: assert property (@(posedge clk) !rst_n |-> !code_valid)
        else $error("code beat during reset");

    a_hold: assert property (@(posedge clk) disable iff (!rst_n)
        code_valid && !code_ready |=> code_valid && $stable(code))
        else $error("stalled code beat changed");

    a_length: assert property (@(posedge clk) disable iff (!rst_n)
        code_valid |-> code.code_length >= 4'd1 && code.code_length <= 4'd8 &&
                       code.char_0 != CHAR_NONE)
        else $error("bad code length");

    a_bang: assert property (@(posedge clk) disable iff (!rst_n)
        code_valid && code.char_0 == CHAR_BANG |->
            code.code_length == 4'd1 && code.char_1 == CHAR_NONE)
        else $error("out of range code malformed");

    a_tail: assert property (@(posedge clk) disable iff (!rst_n)
        code_valid && code.code_length != 4'd8 |-> code.char_7 == CHAR_NONE)
        else $error("character past code length");

endmodule

bind geohash_tile_encoder gte_checker u_gte_checker (
    .clk         (clk),
    .rst_n       (rst_n),
    .point_valid (point_valid),
    .point_ready (point_ready),
    .point       (point),
    .code_valid  (code_valid),
    .code_ready  (code_ready),
    .code        (code)
);

// File: bench/tb_top.sv
`timescale 1ns / 100ps

module tb_top;

    import gte_pkg::*;

    localparam int GEO_DEPTH = 19;
    localparam int GEO_SCALE = 19;
    localparam longint GEO_LON_HALF = 64'sd1800000000;
    localparam longint GEO_LAT_HALF = 64'sd900000000;
    localparam logic [63:0] GEO_LON_SPAN = 64'd3600000000;
    localparam logic [63:0] GEO_LAT_SPAN = 64'd1800000000;
    localparam logic [255:0] GEO_ALPHABET = "0123456789bcdefghjkmnpqrstuvwxyz";
    localparam int unsigned TOL_STEPS [GEO_DEPTH] = '{
        5400000, 2700000, 1300000, 680000, 340000, 170000, 85000, 42000, 21000,
        10000, 5300, 2600, 1300, 650, 320, 160, 83, 41, 20
    };
    localparam int RANDOM_POINTS = 1850;
    localparam int MAX_GAP = 12;

    logic   clk = 1'b0;
    logic   rst_n;
    logic   point_valid = 1'b0;
    logic   point_ready;
    point_t point = '0;
    logic   code_valid;
    logic   code_ready = 1'b0;
    code_t  code;

    code_t  pending_codes [$];
    int     mismatch_cnt = 0;
    int     ready_hold = 0;
    int     code_beats = 0;
    int     beats_seen = 0;
    bit     idle_on = 1'b1;

    geohash_tile_encoder #(
        .MAX_DEPTH   (GEO_DEPTH)
    ) dut (
        .clk         (clk),
        .rst_n       (rst_n),
        .point_valid (point_valid),
        .point_ready (point_ready),
        .point       (point),
        .code_valid  (code_valid),
        .code_ready  (code_ready),
        .code        (code)
    );

    always #5 clk = ~clk;

    function automatic logic [6:0] alpha_char(input logic [4:0] idx);
        return GEO_ALPHABET[8 * (31 - int'(idx)) +: 7];
    endfunction

    function automatic code_t encode_point(input point_t p);
        code_t c;
        logic [6:0] ch [NUM_CHARS];
        longint lon;
        longint lat;
        logic [63:0] xpos, ypos, xlo, xhi, ylo, yhi, mid;
        logic [39:0] path;
        int levels;
        int groups;
        int rem_bits;
        lon = $signed(p.longitude);
        lat = $signed(p.latitude);
        for (int i = 0; i < NUM_CHARS; i++)
            ch[i] = CHAR_NONE;
        path = '0;
        levels = 0;
        if (lon < -GEO_LON_HALF || lon > GEO_LON_HALF ||
            lat < -GEO_LAT_HALF || lat > GEO_LAT_HALF)
        begin
            ch[0] = CHAR_BANG;
            c.code_length = 4'd1;
        end
        else
        begin
            xpos = 64'(lon + GEO_LON_HALF) << GEO_SCALE;
            ypos = 64'(lat + GEO_LAT_HALF) << GEO_SCALE;
            xlo = '0;
            xhi = GEO_LON_SPAN << GEO_SCALE;
            ylo = '0;
            yhi = GEO_LAT_SPAN << GEO_SCALE;
            while (levels < GEO_DEPTH && int'(p.tolerance) <= TOL_STEPS[levels])
            begin
                mid = (xlo + xhi) >> 1;
                if (xpos >= mid)
                begin
                    xlo = mid;
                    path = {path[38:0], 1'b1};
                end
                else
                begin
                    xhi = mid;
                    path = {path[38:0], 1'b0};
                end
                mid = (ylo + yhi) >> 1;
                if (ypos >= mid)
                begin
                    ylo = mid;
                    path = {path[38:0], 1'b1};
                end
                else
                begin
                    yhi = mid;
                    path = {path[38:0], 1'b0};
                end
                levels++;
            end
            groups = (2 * levels) / 5;
            rem_bits = (2 * levels) % 5;
            for (int g = 0; g < groups; g++)
                ch[g] = alpha_char(5'(path >> ((groups - 1 - g) * 5 + rem_bits)));
            // leftover bits pad to a full character; '0' when none remain
            ch[groups] = alpha_char(5'(path << (5 - rem_bits)));
            c.code_length = 4'(groups + 1);
        end
        c.char_0 = ch[0];
        c.char_1 = ch[1];
        c.char_2 = ch[2];
        c.char_3 = ch[3];
        c.char_4 = ch[4];
        c.char_5 = ch[5];
        c.char_6 = ch[6];
        c.char_7 = ch[7];
        return c;
    endfunction

    function automatic point_t make_point(input longint lon, input longint lat,
                                          input int unsigned tol);
        point_t p;
        p.longitude = 32'(lon);
        p.latitude  = 32'(lat);
        p.tolerance = 24'(tol);
        return p;
    endfunction

    function automatic point_t random_point();
        longint lon;
        longint lat;
        int unsigned sel;
        int unsigned k;
        int unsigned tol;
        int unsigned lvl;
        sel = $urandom_range(0, 99);
        if (sel < 8)
        begin
            lon = $signed($urandom);
            lat = $signed($urandom);
        end
        else if (sel < 32)
        begin
            // grid-aligned: lands exactly on bisection midpoints
            k = $urandom_range(1, 10);
            lon = longint'($urandom_range(0, 1 << k)) * longint'(GEO_LON_SPAN >> k)
                  - GEO_LON_HALF;
            k = $urandom_range(1, 9);
            lat = longint'($urandom_range(0, 1 << k)) * longint'(GEO_LAT_SPAN >> k)
                  - GEO_LAT_HALF;
        end
        else if (sel < 40)
        begin
            lon = ($urandom_range(0, 1) ? GEO_LON_HALF : -GEO_LON_HALF)
                  + longint'($urandom_range(0, 2)) - 1;
            lat = ($urandom_range(0, 1) ? GEO_LAT_HALF : -GEO_LAT_HALF)
                  + longint'($urandom_range(0, 2)) - 1;
        end
        else
        begin
            lon = longint'($urandom_range(0, 32'd3600000000)) - GEO_LON_HALF;
            lat = longint'($urandom_range(0, 32'd1800000000)) - GEO_LAT_HALF;
        end
        sel = $urandom_range(0, 99);
        lvl = $urandom_range(0, GEO_DEPTH - 1);
        if (sel < 40)
            tol = TOL_STEPS[lvl] + $urandom_range(0, 2) - 1;
        else if (sel < 70)
            tol = $urandom_range(0, 25);
        else if (sel < 90)
            tol = $urandom_range(0, 5400001);
        else
            tol = $urandom_range(0, 24'hffffff);
        return make_point(lon, lat, tol);
    endfunction

    task automatic report_mismatch(input string what, input longint got, input longint want);
        if (mismatch_cnt < 200)
            $display("%0t mismatch %s: got %0d expected %0d", $time, what, got, want);
        mismatch_cnt++;
    endtask

    // scoreboard: predict on point beat, compare on code beat
    always @(posedge clk)
    begin
        code_t want;
        if (rst_n)
        begin
            if (point_valid && point_ready)
                pending_codes.push_back(encode_point(point));
            if (code_valid && code_ready)
            begin
                code_beats++;
                if (pending_codes.size() == 0)
                    report_mismatch("code beat with nothing pending", code.code_length, 0);
                else
                begin
                    want = pending_codes.pop_front();
                    if (code.char_0 !== want.char_0)
                        report_mismatch("char_0", code.char_0, want.char_0);
                    if (code.char_1 !== want.char_1)
                        report_mismatch("char_1", code.char_1, want.char_1);
                    if (code.char_2 !== want.char_2)
                        report_mismatch("char_2", code.char_2, want.char_2);
                    if (code.char_3 !== want.char_3)
                        report_mismatch("char_3", code.char_3, want.char_3);
                    if (code.char_4 !== want.char_4)
                        report_mismatch("char_4", code.char_4, want.char_4);
                    if (code.char_5 !== want.char_5)
                        report_mismatch("char_5", code.char_5, want.char_5);
                    if (code.char_6 !== want.char_6)
                        report_mismatch("char_6", code.char_6, want.char_6);
                    if (code.char_7 !== want.char_7)
                        report_mismatch("char_7", code.char_7, want.char_7);
                    if (code.code_length !== want.code_length)
                        report_mismatch("code_length", code.code_length, want.code_length);
                end
            end
        end
    end

    // output backpressure
    always @(negedge clk)
    begin
        if (beats_seen != code_beats)
        begin
            beats_seen = code_beats;
            ready_hold = idle_on ? $urandom_range(0, MAX_GAP) : 0;
        end
        if (ready_hold > 0)
        begin
            code_ready <= 1'b0;
            ready_hold = ready_hold - 1;
        end
        else
            code_ready <= 1'b1;
    end

    // called and returns at a falling edge
    task automatic send_point(input point_t p);
        int gap;
        gap = idle_on ? $urandom_range(0, MAX_GAP) : 0;
        if (gap > 0)
        begin
            point_valid <= 1'b0;
            repeat (gap) @(negedge clk);
        end
        point_valid <= 1'b1;
        point <= p;
        do
            @(posedge clk);
        while (!point_ready);
        @(negedge clk);
    endtask

    task automatic drain_codes();
        point_valid <= 1'b0;
        do
            @(negedge clk);
        while (pending_codes.size() != 0);
    endtask

    task automatic test_range_edges();
        send_point(make_point(-GEO_LON_HALF, -GEO_LAT_HALF, 0));
        send_point(make_point(GEO_LON_HALF, GEO_LAT_HALF, 0));
        send_point(make_point(0, 0, 20));
        send_point(make_point(GEO_LON_HALF + 1, 0, 0));
        send_point(make_point(0, -GEO_LAT_HALF - 1, 0));
        send_point(make_point(-64'sd2147483648, 64'sd2147483647, 24'hffffff));
    endtask

    task automatic test_depth_levels();
        for (int i = 0; i < GEO_DEPTH; i++)
        begin
            send_point(make_point(37 * i * 1000003 - 900000000, 123456789 - i * 47000001,
                                  TOL_STEPS[i]));
        end
        send_point(make_point(1234567, -7654321, 5400001));
        send_point(make_point(-1234567, 7654321, 24'hffffff));
    endtask

    task automatic test_drain_pause();
        for (int i = 0; i < 40; i++)
            send_point(random_point());
        drain_codes();
    endtask

    task automatic test_random_points();
        for (int n = 0; n < RANDOM_POINTS; n++)
        begin
            if (n % 150 == 0)
                idle_on = ($urandom_range(0, 3) != 0);
            if (n % 400 == 399)
                drain_codes();
            send_point(random_point());
        end
    endtask

    initial
    begin
        rst_n <= 1'b0;
        repeat (5) @(negedge clk);
        rst_n <= 1'b1;
        @(negedge clk);
        test_range_edges();
        test_depth_levels();
        idle_on = 1'b0;
        test_drain_pause();
        idle_on = 1'b1;
        test_drain_pause();
        test_random_points();
        drain_codes();
        repeat (GEO_DEPTH + 20) @(posedge clk);
        if (mismatch_cnt == 0)
            $display("[geohash_tile_encoder] OK");
        else
            $display("[geohash_tile_encoder] ERROR");
        $finish;
    end

    initial
    begin
        #5000000;
        $display("[geohash_tile_encoder] ERROR");
        $finish;
    end

endmodule

// File: files.f
rtl/gte_pkg.sv
rtl/geohash_tile_encoder.sv
rtl/gte_checker.sv
bench/tb_top.sv
